[hw/rtl/nprs_pkg.sv]
// shared types and constants for the nand page read sequencer
package nprs_pkg;

   localparam int unsigned SMALL_PAGE_BYTES = 512;
   localparam int unsigned LARGE_PAGE_BYTES = 2048;

   localparam int unsigned SMALL_SHIFT = $clog2(SMALL_PAGE_BYTES);
   localparam int unsigned LARGE_SHIFT = $clog2(LARGE_PAGE_BYTES);
   localparam int unsigned COL_W       = LARGE_SHIFT + 1;
   localparam int unsigned CYC_W       = 3;

   localparam int unsigned SMALL_ADDR_CYCLES = 4;
   localparam int unsigned LARGE_ADDR_CYCLES = 5;

   // small page address cycle shifts
   localparam int unsigned SMALL_ADDR_SHIFT_1 = 9;
   localparam int unsigned SMALL_ADDR_SHIFT_2 = 17;
   localparam int unsigned SMALL_ADDR_SHIFT_3 = 25;

   localparam logic [7:0] CMD_READ      = 8'h00;
   localparam logic [7:0] CMD_READSTART = 8'h30;

   typedef enum logic [0:0] {
      OP_START = 1'b0,
      OP_TICK  = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      ACT_IDLE     = 3'd0,
      ACT_SELECT   = 3'd1,
      ACT_COMMAND  = 3'd2,
      ACT_ADDRESS  = 3'd3,
      ACT_DATA     = 3'd4,
      ACT_DESELECT = 3'd5
   } action_type;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_SELECT   = 3'd1,
      PH_CMD0     = 3'd2,
      PH_ADDR     = 3'd3,
      PH_CMD30    = 3'd4,
      PH_WAIT     = 3'd5,
      PH_READ     = 3'd6,
      PH_DESELECT = 3'd7
   } phase_type;

endpackage

[hw/rtl/nand_page_read_sequencer_top.sv]
// nand page read sequencer: one bus action result per request
//
//  channel | direction | handshake           | payload
//  req_    | in        | req_valid/req_stall | opcode, start_address, byte_count,
//          |           |                     | flash_ready, flash_data
//  rsp_    | out       | rsp_valid/rsp_stall | bus_action, bus_byte, byte_index,
//          |           |                     | done_res
//  csr_    | in        | csr_valid/csr_ready | large_page
//
// one request per cycle while req_stall is low; an accepted request loads its result into the output register
// the sequencer state and result are computed in a single pass from the state registers
// reset clears the phase to idle, the geometry to small pages and the output valid flag
// req_stall rises only while a result is held and rsp_stall is high
module nand_page_read_sequencer_top
   import nprs_pkg::*;
(
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_opcode,
   input  logic [31:0] req_start_address,
   input  logic [31:0] req_byte_count,
   input  logic        req_flash_ready,
   input  logic [7:0]  req_flash_data,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_bus_action,
   output logic [7:0]  rsp_bus_byte,
   output logic [31:0] rsp_byte_index,
   output logic        rsp_done_res,

   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic        csr_large_page
);

   logic              large_page_ff;
   phase_type         phase_ff, phase_in;
   logic [31:0]       addr_ff, addr_in;
   logic [31:0]       left_ff, left_in;
   logic [31:0]       count_ff, count_in;
   logic [COL_W-1:0]  column_ff, column_in;
   logic [CYC_W-1:0]  cyc_ff, cyc_in;

   logic              rsp_valid_ff, rsp_valid_in;
   action_type        act_ff, act_in;
   logic [7:0]        byte_ff, byte_in;
   logic [31:0]       index_ff, index_in;
   logic              done_ff, done_in;

   logic              accept;
   logic [COL_W-1:0]  page_bytes;
   logic [COL_W-1:0]  col_start;
   logic [COL_W-1:0]  col_inc;
   logic [31:0]       left_dec;
   logic [31:0]       page_idx;
   logic [7:0]        addr_byte;
   logic              addr_last;

   assign csr_ready = 1'b1;
   assign req_stall = rsp_valid_ff & rsp_stall;
   assign accept    = req_valid & ~req_stall;

   assign page_bytes = large_page_ff ? COL_W'(LARGE_PAGE_BYTES) : COL_W'(SMALL_PAGE_BYTES);
   assign col_start  = large_page_ff ? COL_W'(req_start_address[LARGE_SHIFT-1:0])
                                     : COL_W'(req_start_address[SMALL_SHIFT-1:0]);
   assign col_inc    = column_ff + COL_W'(1);
   assign left_dec   = left_ff - 32'd1;
   assign page_idx   = addr_ff >> LARGE_SHIFT;

   // address cycle byte
   always_comb begin
      addr_byte = 8'h00;
      if (large_page_ff) begin
         unique case (cyc_ff)
            3'd0:    addr_byte = column_ff[7:0];
            3'd1:    addr_byte = 8'(column_ff >> 8);
            3'd2:    addr_byte = page_idx[7:0];
            3'd3:    addr_byte = page_idx[15:8];
            default: addr_byte = page_idx[23:16];
         endcase
         addr_last = cyc_ff >= CYC_W'(LARGE_ADDR_CYCLES - 1);
      end else begin
         unique case (cyc_ff)
            3'd0:    addr_byte = addr_ff[7:0];
            3'd1:    addr_byte = 8'(addr_ff >> SMALL_ADDR_SHIFT_1);
            3'd2:    addr_byte = 8'(addr_ff >> SMALL_ADDR_SHIFT_2);
            default: addr_byte = 8'(addr_ff >> SMALL_ADDR_SHIFT_3);
         endcase
         addr_last = cyc_ff >= CYC_W'(SMALL_ADDR_CYCLES - 1);
      end
   end

   // next state
   always_comb begin
      phase_in  = phase_ff;
      addr_in   = addr_ff;
      left_in   = left_ff;
      count_in  = count_ff;
      column_in = column_ff;
      cyc_in    = cyc_ff;
      if (req_opcode == OP_START) begin
         addr_in   = req_start_address;
         left_in   = req_byte_count;
         count_in  = 32'd0;
         column_in = col_start;
         cyc_in    = '0;
         phase_in  = PH_SELECT;
      end else begin
         unique case (phase_ff)
            PH_IDLE:     phase_in = PH_IDLE;
            PH_SELECT:   phase_in = (left_ff == 32'd0) ? PH_DESELECT : PH_CMD0;
            PH_CMD0: begin
               cyc_in   = '0;
               phase_in = PH_ADDR;
            end
            PH_ADDR: begin
               if (addr_last) begin
                  cyc_in   = '0;
                  phase_in = large_page_ff ? PH_CMD30 : PH_WAIT;
               end else begin
                  cyc_in = cyc_ff + CYC_W'(1);
               end
            end
            PH_CMD30:    phase_in = PH_WAIT;
            PH_WAIT: begin
               if (req_flash_ready) begin
                  phase_in = PH_READ;
               end
            end
            PH_READ: begin
               count_in  = count_ff + 32'd1;
               left_in   = left_dec;
               addr_in   = addr_ff + 32'd1;
               column_in = col_inc;
               if (left_dec == 32'd0) begin
                  phase_in = PH_DESELECT;
               end else if (col_inc >= page_bytes) begin
                  column_in = '0;
                  phase_in  = PH_CMD0;
               end
            end
            PH_DESELECT: phase_in = PH_IDLE;
         endcase
      end
   end

   // result fields
   always_comb begin
      act_in   = ACT_IDLE;
      byte_in  = 8'h00;
      index_in = 32'd0;
      done_in  = 1'b0;
      if (req_opcode == OP_TICK) begin
         unique case (phase_ff)
            PH_IDLE:     act_in = ACT_IDLE;
            PH_SELECT:   act_in = ACT_SELECT;
            PH_CMD0: begin
               act_in  = ACT_COMMAND;
               byte_in = CMD_READ;
            end
            PH_ADDR: begin
               act_in  = ACT_ADDRESS;
               byte_in = addr_byte;
            end
            PH_CMD30: begin
               act_in  = ACT_COMMAND;
               byte_in = CMD_READSTART;
            end
            PH_WAIT:     act_in = ACT_IDLE;
            PH_READ: begin
               act_in   = ACT_DATA;
               byte_in  = req_flash_data;
               index_in = count_ff;
            end
            PH_DESELECT: begin
               act_in  = ACT_DESELECT;
               done_in = 1'b1;
            end
         endcase
      end
   end

   assign rsp_valid_in = accept | (rsp_valid_ff & rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff      <= PH_IDLE;
         large_page_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (accept) begin
            phase_ff <= phase_in;
         end
         if (csr_valid && csr_ready) begin
            large_page_ff <= csr_large_page;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         addr_ff   <= addr_in;
         left_ff   <= left_in;
         count_ff  <= count_in;
         column_ff <= column_in;
         cyc_ff    <= cyc_in;
         act_ff    <= act_in;
         byte_ff   <= byte_in;
         index_ff  <= index_in;
         done_ff   <= done_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_bus_action = act_ff;
   assign rsp_bus_byte   = byte_ff;
   assign rsp_byte_index = index_ff;
   assign rsp_done_res   = done_ff;

endmodule

[hw/rtl/nprs_checker.sv]
// port-level assertions for the nand page read sequencer, bound to the top level
module nprs_checker
   import nprs_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        req_opcode,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [2:0]  rsp_bus_action,
   input logic [7:0]  rsp_bus_byte,
   input logic [31:0] rsp_byte_index,
   input logic        rsp_done_res
);

   // held result stays put
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_bus_action)
         && $stable(rsp_bus_byte) && $stable(rsp_byte_index) && $stable(rsp_done_res))
      else $error("held result changed");

   // every accepted request yields a result next cycle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted request produced no result");

   // a start request answers idle
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_opcode == OP_START |=>
         rsp_bus_action == ACT_IDLE && !rsp_done_res)
      else $error("start request did not answer idle");

   // input backpressure only from a stalled full output
   assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("request stalled without output backpressure");

endmodule

bind nand_page_read_sequencer_top nprs_checker u_nprs_checker (.*);

[test/tb.sv]
// testbench for the nand page read sequencer: predicted bus actions checked per request
`timescale 1ns / 100ps

module tb;
   import nprs_pkg::*;

   localparam int unsigned ITEMS         = 1250;
   localparam int unsigned HOLD_CYCLES   = 400;
   localparam int unsigned WATCHDOG_LIMIT = 3000;

   typedef struct packed {
      action_type  act;
      logic [7:0]  bus_byte;
      logic [31:0] byte_index;
      logic        done;
   } bus_result_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;

   logic        req_valid = 1'b0;
   logic        req_stall;
   logic        req_opcode = 1'b0;
   logic [31:0] req_start_address = '0;
   logic [31:0] req_byte_count = '0;
   logic        req_flash_ready = 1'b0;
   logic [7:0]  req_flash_data = '0;

   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [2:0]  rsp_bus_action;
   logic [7:0]  rsp_bus_byte;
   logic [31:0] rsp_byte_index;
   logic        rsp_done_res;

   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_large_page = 1'b0;

   // predicted sequencer state
   phase_type   seq_phase = PH_IDLE;
   logic [31:0] seq_address = '0;
   logic [31:0] seq_left = '0;
   logic [31:0] seq_done = '0;
   int unsigned seq_column = 0;
   logic [2:0]  seq_cycle = '0;
   logic        seq_large = 1'b0;

   bus_result_type expected_actions[$];
   int unsigned errors = 0;
   int unsigned items_sent = 0;
   int unsigned idle_cycles = 0;
   logic        quiet = 1'b0;
   logic        hold_off_wanted = 1'b0;
   logic        hold_off_taken = 1'b0;
   int unsigned hold_off_left = 0;

   nand_page_read_sequencer_top i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_opcode        (req_opcode),
      .req_start_address (req_start_address),
      .req_byte_count    (req_byte_count),
      .req_flash_ready   (req_flash_ready),
      .req_flash_data    (req_flash_data),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_bus_action    (rsp_bus_action),
      .rsp_bus_byte      (rsp_bus_byte),
      .rsp_byte_index    (rsp_byte_index),
      .rsp_done_res      (rsp_done_res),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_large_page    (csr_large_page)
   );

   initial forever #5 clock = ~clock;

   function automatic bus_result_type next_bus_action(op_type op, logic [31:0] addr,
                                                      logic [31:0] count, logic ready,
                                                      logic [7:0] data);
      bus_result_type r;
      int unsigned page_len;
      logic [31:0] page;
      logic [31:0] b;
      bit          last_cycle;
      r = '{act: ACT_IDLE, bus_byte: 8'h00, byte_index: 32'd0, done: 1'b0};
      page_len = seq_large ? LARGE_PAGE_BYTES : SMALL_PAGE_BYTES;
      if (op == OP_START) begin
         seq_address = addr;
         seq_left    = count;
         seq_done    = '0;
         seq_column  = addr % page_len;
         seq_cycle   = '0;
         seq_phase   = PH_SELECT;
         return r;
      end
      case (seq_phase)
         PH_SELECT: begin
            r.act = ACT_SELECT;
            seq_phase = (seq_left == 0) ? PH_DESELECT : PH_CMD0;
         end
         PH_CMD0: begin
            r.act = ACT_COMMAND;
            r.bus_byte = CMD_READ;
            seq_cycle = '0;
            seq_phase = PH_ADDR;
         end
         PH_ADDR: begin
            if (seq_large) begin
               page = seq_address / LARGE_PAGE_BYTES;
               case (seq_cycle)
                  3'd0:    b = seq_column;
                  3'd1:    b = seq_column >> 8;
                  3'd2:    b = page;
                  3'd3:    b = page >> 8;
                  default: b = page >> 16;
               endcase
               last_cycle = seq_cycle >= 3'd4;
            end else begin
               case (seq_cycle)
                  3'd0:    b = seq_address;
                  3'd1:    b = seq_address >> 9;
                  3'd2:    b = seq_address >> 17;
                  default: b = seq_address >> 25;
               endcase
               last_cycle = seq_cycle >= 3'd3;
            end
            r.act = ACT_ADDRESS;
            r.bus_byte = b[7:0];
            if (last_cycle) begin
               seq_cycle = '0;
               seq_phase = seq_large ? PH_CMD30 : PH_WAIT;
            end else begin
               seq_cycle = seq_cycle + 3'd1;
            end
         end
         PH_CMD30: begin
            r.act = ACT_COMMAND;
            r.bus_byte = CMD_READSTART;
            seq_phase = PH_WAIT;
         end
         PH_WAIT: begin
            if (ready) seq_phase = PH_READ;
         end
         PH_READ: begin
            r.act = ACT_DATA;
            r.bus_byte = data;
            r.byte_index = seq_done;
            seq_done    = seq_done + 32'd1;
            seq_left    = seq_left - 32'd1;
            seq_address = seq_address + 32'd1;
            seq_column  = seq_column + 1;
            if (seq_left == 0) begin
               seq_phase = PH_DESELECT;
            end else if (seq_column >= page_len) begin
               seq_column = 0;
               seq_phase = PH_CMD0;
            end
         end
         PH_DESELECT: begin
            r.act = ACT_DESELECT;
            r.done = 1'b1;
            seq_phase = PH_IDLE;
         end
         default: begin
            seq_phase = PH_IDLE;
         end
      endcase
      return r;
   endfunction

   task automatic send_request(op_type op, logic [31:0] addr, logic [31:0] count,
                               logic ready, logic [7:0] data);
      if (!quiet) begin
         while ($urandom_range(99) < 13) begin
            req_valid <= 1'b0;
            @(posedge clock);
         end
      end
      req_valid         <= 1'b1;
      req_opcode        <= op;
      req_start_address <= addr;
      req_byte_count    <= count;
      req_flash_ready   <= ready;
      req_flash_data    <= data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      expected_actions.push_back(next_bus_action(op, addr, count, ready, data));
      items_sent++;
   endtask

   task automatic start_read(logic [31:0] addr, logic [31:0] count);
      send_request(OP_START, addr, count, 1'($urandom_range(1)), 8'($urandom_range(255)));
   endtask

   task automatic tick(logic ready, logic [7:0] data);
      send_request(OP_TICK, $urandom, $urandom, ready, data);
   endtask

   task automatic finish_read();
      while (seq_phase != PH_IDLE) tick($urandom_range(3) != 0, 8'($urandom_range(255)));
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_actions.size() != 0) @(posedge clock);
   endtask

   task automatic set_geometry(logic want_large);
      wait_drained();
      csr_valid      <= 1'b1;
      csr_large_page <= want_large;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      seq_large = want_large;
      csr_valid <= 1'b0;
   endtask

   task automatic test_small_page();
      set_geometry(1'b0);
      tick(1'b1, 8'hA5);
      start_read($urandom, 32'd0);
      finish_read();
      // read across a page end with a busy flash first
      start_read(32'h0000_01FF, 32'd2);
      repeat (6) tick(1'b1, 8'h00);
      tick(1'b0, 8'h00);
      tick(1'b1, 8'h00);
      tick(1'b1, 8'hFF);
      finish_read();
      // address wraps past the top
      start_read(32'hFFFF_FFFF, 32'd2);
      finish_read();
   endtask

   task automatic test_large_page();
      set_geometry(1'b1);
      start_read(32'hFFFF_FFFE, 32'd3);
      finish_read();
      // restart while busy, also straight after a start
      start_read($urandom, 32'hFFFF_FFFF);
      repeat (9) tick(1'b1, 8'($urandom_range(255)));
      start_read(32'h0000_0800, 32'd5);
      start_read(32'h0000_0000, 32'd1);
      finish_read();
   endtask

   task automatic test_geometry_change();
      // large column left over when pages shrink, address cycle past the small count
      set_geometry(1'b1);
      start_read(32'h0000_07F0, 32'd6);
      repeat (6) tick(1'b1, 8'($urandom_range(255)));
      set_geometry(1'b0);
      finish_read();
      // small to large in the middle of the address cycles
      start_read(32'h0000_01FF, 32'd3);
      repeat (5) tick(1'b1, 8'($urandom_range(255)));
      set_geometry(1'b1);
      finish_read();
   endtask

   task automatic test_backpressure();
      int unsigned first;
      wait_drained();
      hold_off_wanted <= 1'b1;
      first = items_sent;
      start_read($urandom, 32'd30);
      while (items_sent < first + 40) tick(1'b1, 8'($urandom_range(255)));
      finish_read();
   endtask

   task automatic test_random();
      int unsigned page_len;
      int unsigned roll;
      int unsigned ticks;
      int unsigned limit;
      logic [31:0] addr;
      logic [31:0] count;
      bit          abandon;
      while (items_sent < ITEMS) begin
         quiet <= (items_sent >= 500 && items_sent < 700);
         if ($urandom_range(99) < 4) set_geometry(1'($urandom_range(1)));
         roll = $urandom_range(99);
         if (roll < 6) begin
            tick(1'($urandom_range(1)), 8'($urandom_range(255)));
            continue;
         end
         page_len = seq_large ? LARGE_PAGE_BYTES : SMALL_PAGE_BYTES;
         addr = $urandom;
         if ($urandom_range(1))
            addr = (addr & ~(page_len - 1)) | (page_len - $urandom_range(1, 6));
         abandon = roll < 18;
         if (abandon) count = $urandom;
         else if (roll < 26) count = 32'd0;
         else count = $urandom_range(1, 24);
         start_read(addr, count);
         limit = $urandom_range(0, 30);
         ticks = 0;
         while (seq_phase != PH_IDLE && (!abandon || ticks < limit)) begin
            if (!abandon && $urandom_range(99) < 2) set_geometry(!seq_large);
            tick($urandom_range(3) != 0, 8'($urandom_range(255)));
            ticks++;
         end
      end
      quiet <= 1'b0;
   endtask

   always @(posedge clock) begin : check_results
      bus_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_actions.size() == 0) begin
            $display("%0t: unexpected result, action %0d", $time, rsp_bus_action);
            errors++;
         end else begin
            want = expected_actions.pop_front();
            if (rsp_bus_action !== want.act) begin
               $display("%0t: bus_action expected %0d got %0d", $time, want.act,
                        rsp_bus_action);
               errors++;
            end
            if (rsp_bus_byte !== want.bus_byte) begin
               $display("%0t: bus_byte expected %h got %h", $time, want.bus_byte,
                        rsp_bus_byte);
               errors++;
            end
            if (rsp_byte_index !== want.byte_index) begin
               $display("%0t: byte_index expected %h got %h", $time, want.byte_index,
                        rsp_byte_index);
               errors++;
            end
            if (rsp_done_res !== want.done) begin
               $display("%0t: done_res expected %b got %b", $time, want.done,
                        rsp_done_res);
               errors++;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_off_left > 0) begin
         rsp_stall <= 1'b1;
         hold_off_left <= hold_off_left - 1;
      end else if (hold_off_wanted && !hold_off_taken) begin
         rsp_stall <= 1'b1;
         hold_off_left <= HOLD_CYCLES;
         hold_off_taken <= 1'b1;
      end else begin
         rsp_stall <= !quiet && $urandom_range(99) < 13;
      end
   end

   always @(posedge clock) begin
      if ((req_valid && !req_stall) || (rsp_valid && !rsp_stall) || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb NOT OK");
         $finish;
      end else
         idle_cycles <= idle_cycles + 1;
   end

   initial begin
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      test_small_page();
      test_large_page();
      test_geometry_change();
      test_backpressure();
      test_random();
      wait_drained();
      repeat (4) @(posedge clock);
      if (errors == 0)
         $display("tb OK");
      else
         $display("tb NOT OK");
      $finish;
   end

endmodule
